[rtl/core/cbbc_pkg.sv]
package cbbc_pkg;

   // Saturation widths of the bracket depths and of the line counter.
   localparam int COUNT_BITS = 16;
   localparam int LINE_BITS  = 24;

   // Widths of the result fields, which are clamped on output.
   localparam int ERROR_LINE_W = 24;
   localparam int UNCLOSED_W   = 16;
   localparam logic [31:0] ERROR_LINE_MAX = 32'h00FF_FFFF;
   localparam logic [31:0] UNCLOSED_MAX   = 32'h0000_FFFF;

   // Request kinds carried in one input word.
   localparam logic REQ_TEXT = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // Characters that the scanner reacts to.
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;

   typedef enum logic [2:0] {
      MODE_CODE,
      MODE_STRING,
      MODE_CHAR,
      MODE_LINE_COMMENT,
      MODE_BLOCK_COMMENT
   } lex_mode_type;

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_SLASH,
      PEND_STAR,
      PEND_ESCAPE
   } pend_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_PAREN,
      ERR_BRACE,
      ERR_BRACKET
   } err_type;

   typedef enum logic [3:0] {
      ST_OK,
      ST_STRAY_PAREN,
      ST_STRAY_BRACE,
      ST_STRAY_BRACKET,
      ST_OPEN_STRING,
      ST_OPEN_COMMENT,
      ST_OPEN_BRACES,
      ST_OPEN_PARENS,
      ST_OPEN_BRACKETS
   } status_type;

   typedef struct packed {
      lex_mode_type          mode;
      pend_type              pend;
      logic [COUNT_BITS-1:0] paren;
      logic [COUNT_BITS-1:0] brace;
      logic [COUNT_BITS-1:0] bracket;
      logic [LINE_BITS-1:0]  line;
      err_type               err;
      logic [LINE_BITS-1:0]  err_line;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      mode:     MODE_CODE,
      pend:     PEND_NONE,
      paren:    '0,
      brace:    '0,
      bracket:  '0,
      line:     LINE_BITS'(1),
      err:      ERR_NONE,
      err_line: '0
   };

endpackage

[rtl/core/cbbc_lexer.sv]
module cbbc_lexer (
   input  cbbc_pkg::scan_state_type cur_state,
   input  logic [7:0]               text_byte,
   output cbbc_pkg::scan_state_type next_state
);
   import cbbc_pkg::*;

   localparam logic [COUNT_BITS-1:0] DEPTH_MAX = '1;
   localparam logic [LINE_BITS-1:0]  LINE_MAX  = '1;

   logic [7:0] quote_char;

   assign quote_char = (cur_state.mode == MODE_STRING) ? CH_DQUOTE : CH_SQUOTE;

   always_comb begin
      next_state = cur_state;
      if (cur_state.err == ERR_NONE) begin
         if (text_byte == CH_NEWLINE && cur_state.line != LINE_MAX) begin
            next_state.line = cur_state.line + 1'b1;
         end
         case (cur_state.mode)
            MODE_STRING, MODE_CHAR: begin
               next_state.pend = PEND_NONE;
               if (cur_state.pend != PEND_ESCAPE) begin
                  if (text_byte == CH_BACKSLASH) begin
                     next_state.pend = PEND_ESCAPE;
                  end else if (text_byte == quote_char) begin
                     next_state.mode = MODE_CODE;
                  end
               end
            end
            MODE_LINE_COMMENT: begin
               next_state.pend = PEND_NONE;
               if (text_byte == CH_NEWLINE) begin
                  next_state.mode = MODE_CODE;
               end
            end
            MODE_BLOCK_COMMENT: begin
               if (cur_state.pend == PEND_STAR && text_byte == CH_SLASH) begin
                  next_state.pend = PEND_NONE;
                  next_state.mode = MODE_CODE;
               end else if (text_byte == CH_STAR) begin
                  next_state.pend = PEND_STAR;
               end else begin
                  next_state.pend = PEND_NONE;
               end
            end
            default: begin
               next_state.mode = MODE_CODE;
               next_state.pend = PEND_NONE;
               if (cur_state.pend == PEND_SLASH && text_byte == CH_SLASH) begin
                  next_state.mode = MODE_LINE_COMMENT;
               end else if (cur_state.pend == PEND_SLASH && text_byte == CH_STAR) begin
                  next_state.mode = MODE_BLOCK_COMMENT;
               end else begin
                  case (text_byte)
                     CH_DQUOTE: next_state.mode = MODE_STRING;
                     CH_SQUOTE: next_state.mode = MODE_CHAR;
                     CH_SLASH:  next_state.pend = PEND_SLASH;
                     CH_LPAREN: begin
                        if (cur_state.paren != DEPTH_MAX) begin
                           next_state.paren = cur_state.paren + 1'b1;
                        end
                     end
                     CH_RPAREN: begin
                        if (cur_state.paren == '0) begin
                           next_state.err      = ERR_PAREN;
                           next_state.err_line = cur_state.line;
                        end else begin
                           next_state.paren = cur_state.paren - 1'b1;
                        end
                     end
                     CH_LBRACE: begin
                        if (cur_state.brace != DEPTH_MAX) begin
                           next_state.brace = cur_state.brace + 1'b1;
                        end
                     end
                     CH_RBRACE: begin
                        if (cur_state.brace == '0) begin
                           next_state.err      = ERR_BRACE;
                           next_state.err_line = cur_state.line;
                        end else begin
                           next_state.brace = cur_state.brace - 1'b1;
                        end
                     end
                     CH_LBRACKET: begin
                        if (cur_state.bracket != DEPTH_MAX) begin
                           next_state.bracket = cur_state.bracket + 1'b1;
                        end
                     end
                     CH_RBRACKET: begin
                        if (cur_state.bracket == '0) begin
                           next_state.err      = ERR_BRACKET;
                           next_state.err_line = cur_state.line;
                        end else begin
                           next_state.bracket = cur_state.bracket - 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         endcase
      end
   end

endmodule

[rtl/core/c_source_bracket_balance_checker_top.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_type, req_text_byte
// rsp       out        rsp_valid / rsp_ready  rsp_status, rsp_error_line, rsp_unclosed_count
//
// A text byte updates the scan state at the edge that accepts it,
// and an end word loads the verdict into the result register at its accepting edge.
// Text bytes are taken in every cycle, even while a verdict waits to be taken.
// An end word waits only when the result register is full and rsp_ready is low.
// Synchronous active-high reset returns the scanner to code mode on line one.
module c_source_bracket_balance_checker_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [7:0]                       req_text_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [3:0]                       rsp_status,
   output logic [cbbc_pkg::ERROR_LINE_W-1:0] rsp_error_line,
   output logic [cbbc_pkg::UNCLOSED_W-1:0]   rsp_unclosed_count
);
   import cbbc_pkg::*;

   scan_state_type state_ff, state_in;
   scan_state_type lex_next;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   logic [ERROR_LINE_W-1:0] eline_ff, eline_in;
   logic [UNCLOSED_W-1:0]   count_ff, count_in;

   logic        slot_free;
   logic        accept;
   logic [31:0] line_wide;
   logic [31:0] count_wide;

   // The lexer works out where one text byte leaves the scan state.
   cbbc_lexer u_lexer (
      .cur_state  (state_ff),
      .text_byte  (req_text_byte),
      .next_state (lex_next)
   );

   // The result register is free once empty or being emptied this cycle.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (req_type == REQ_TEXT) || slot_free;
   assign accept    = req_valid && req_ready;

   // The verdict picks a stray closer first, then an open string or block comment, then depths.
   always_comb begin
      status_in  = ST_OK;
      line_wide  = '0;
      count_wide = '0;
      case (state_ff.err)
         ERR_PAREN: begin
            status_in = ST_STRAY_PAREN;
            line_wide = 32'(state_ff.err_line);
         end
         ERR_BRACE: begin
            status_in = ST_STRAY_BRACE;
            line_wide = 32'(state_ff.err_line);
         end
         ERR_BRACKET: begin
            status_in = ST_STRAY_BRACKET;
            line_wide = 32'(state_ff.err_line);
         end
         default: begin
            if (state_ff.mode == MODE_STRING) begin
               status_in = ST_OPEN_STRING;
            end else if (state_ff.mode == MODE_BLOCK_COMMENT) begin
               status_in = ST_OPEN_COMMENT;
            end else if (state_ff.brace != '0) begin
               status_in  = ST_OPEN_BRACES;
               count_wide = 32'(state_ff.brace);
            end else if (state_ff.paren != '0) begin
               status_in  = ST_OPEN_PARENS;
               count_wide = 32'(state_ff.paren);
            end else if (state_ff.bracket != '0) begin
               status_in  = ST_OPEN_BRACKETS;
               count_wide = 32'(state_ff.bracket);
            end
         end
      endcase
      // Clamp to the field widths of the result word.
      eline_in = (line_wide > ERROR_LINE_MAX) ? ERROR_LINE_MAX[ERROR_LINE_W-1:0]
                                              : line_wide[ERROR_LINE_W-1:0];
      count_in = (count_wide > UNCLOSED_MAX) ? UNCLOSED_MAX[UNCLOSED_W-1:0]
                                             : count_wide[UNCLOSED_W-1:0];
   end

   // Next scan state: a text byte advances it, an end word clears it for the next text.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         if (req_type == REQ_TEXT) begin
            state_in = lex_next;
         end else begin
            state_in     = SCAN_RESET;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SCAN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload loads only with an accepted end word.
   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_END) begin
         status_ff <= status_in;
         eline_ff  <= eline_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_error_line     = eline_ff;
   assign rsp_unclosed_count = count_ff;

endmodule

[tb/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cbbc_pkg::*;

   // The watchdog limit is far above the slowest legal run. That run is well under a thousand
   // words, plus the idle gaps of the idling phases and the result stalls on the end words.
   localparam int CYCLE_LIMIT = 50000;

   // Bytes that steer the scanner. Random text draws from this set often, so the
   // lexical modes and the pending marks are exercised far more than with plain bytes.
   localparam logic [7:0] LEXICON [12] = '{
      CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET,
      CH_DQUOTE, CH_SQUOTE, CH_SLASH, CH_STAR, CH_BACKSLASH, CH_NEWLINE
   };

   // Idle and stall percentages of the four random phases. The first phase has no idling at
   // all. The others idle the sender, stall the receiver, and then do both at once.
   localparam int SEND_IDLE [4] = '{0, 49, 0, 23};
   localparam int RSP_STALL [4] = '{0, 0, 49, 23};

   // One verdict as the block reports it at the end of a text.
   typedef struct packed {
      status_type               status;
      logic [ERROR_LINE_W-1:0]  error_line;
      logic [UNCLOSED_W-1:0]    unclosed;
   } verdict_type;

   // The scoreboard keeps its own copy of the scan state. It advances that copy on every
   // accepted word, and queues the verdict that each end word must produce.
   class bracket_scoreboard;
      lex_mode_type          mode;
      pend_type              pend;
      logic [COUNT_BITS-1:0] paren;
      logic [COUNT_BITS-1:0] brace;
      logic [COUNT_BITS-1:0] bracket;
      logic [LINE_BITS-1:0]  line;
      err_type               err;
      logic [LINE_BITS-1:0]  err_line;
      verdict_type           pending_verdicts[$];
      int                    words_seen;
      int                    verdicts_checked;
      int                    mismatches;
      int                    status_tally[9];

      function new();
         clear_scan();
      endfunction

      function void clear_scan();
         mode     = MODE_CODE;
         pend     = PEND_NONE;
         paren    = '0;
         brace    = '0;
         bracket  = '0;
         line     = LINE_BITS'(1);
         err      = ERR_NONE;
         err_line = '0;
      endfunction

      function void latch_stray(err_type kind);
         err      = kind;
         err_line = line;
      endfunction

      // Handles one byte in code mode, once any pending slash has been resolved.
      function void code_byte(logic [7:0] c);
         case (c)
            CH_DQUOTE:   mode = MODE_STRING;
            CH_SQUOTE:   mode = MODE_CHAR;
            CH_SLASH:    pend = PEND_SLASH;
            CH_LPAREN:   if (paren != '1) paren = paren + 1'b1;
            CH_LBRACE:   if (brace != '1) brace = brace + 1'b1;
            CH_LBRACKET: if (bracket != '1) bracket = bracket + 1'b1;
            CH_RPAREN:   if (paren == '0) latch_stray(ERR_PAREN); else paren = paren - 1'b1;
            CH_RBRACE:   if (brace == '0) latch_stray(ERR_BRACE); else brace = brace - 1'b1;
            CH_RBRACKET: begin
               if (bracket == '0) latch_stray(ERR_BRACKET);
               else bracket = bracket - 1'b1;
            end
            default: ;
         endcase
      endfunction

      function void scan_byte(logic [7:0] c);
         if (err != ERR_NONE) return;
         if (c == CH_NEWLINE && line != '1) line = line + 1'b1;
         case (mode)
            MODE_STRING, MODE_CHAR: begin
               if (pend == PEND_ESCAPE) begin
                  pend = PEND_NONE;
               end else begin
                  pend = PEND_NONE;
                  if (c == CH_BACKSLASH) pend = PEND_ESCAPE;
                  else if (c == ((mode == MODE_STRING) ? CH_DQUOTE : CH_SQUOTE))
                     mode = MODE_CODE;
               end
            end
            MODE_LINE_COMMENT: begin
               pend = PEND_NONE;
               if (c == CH_NEWLINE) mode = MODE_CODE;
            end
            MODE_BLOCK_COMMENT: begin
               if (pend == PEND_STAR && c == CH_SLASH) begin
                  pend = PEND_NONE;
                  mode = MODE_CODE;
               end else begin
                  pend = (c == CH_STAR) ? PEND_STAR : PEND_NONE;
               end
            end
            default: begin
               mode = MODE_CODE;
               if (pend == PEND_SLASH && c == CH_SLASH) begin
                  pend = PEND_NONE;
                  mode = MODE_LINE_COMMENT;
               end else if (pend == PEND_SLASH && c == CH_STAR) begin
                  pend = PEND_NONE;
                  mode = MODE_BLOCK_COMMENT;
               end else begin
                  pend = PEND_NONE;
                  code_byte(c);
               end
            end
         endcase
      endfunction

      function verdict_type verdict();
         verdict_type v;
         v = '{status: ST_OK, error_line: '0, unclosed: '0};
         case (err)
            ERR_PAREN:   v.status = ST_STRAY_PAREN;
            ERR_BRACE:   v.status = ST_STRAY_BRACE;
            ERR_BRACKET: v.status = ST_STRAY_BRACKET;
            default:     ;
         endcase
         if (err != ERR_NONE) begin
            v.error_line = ERROR_LINE_W'(err_line);
         end else if (mode == MODE_STRING) begin
            v.status = ST_OPEN_STRING;
         end else if (mode == MODE_BLOCK_COMMENT) begin
            v.status = ST_OPEN_COMMENT;
         end else if (brace != '0) begin
            v.status   = ST_OPEN_BRACES;
            v.unclosed = UNCLOSED_W'(brace);
         end else if (paren != '0) begin
            v.status   = ST_OPEN_PARENS;
            v.unclosed = UNCLOSED_W'(paren);
         end else if (bracket != '0) begin
            v.status   = ST_OPEN_BRACKETS;
            v.unclosed = UNCLOSED_W'(bracket);
         end
         return v;
      endfunction

      function void note_word(logic kind, logic [7:0] c);
         words_seen++;
         if (kind == REQ_TEXT) begin
            scan_byte(c);
         end else begin
            pending_verdicts.push_back(verdict());
            clear_scan();
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic [3:0] st, logic [ERROR_LINE_W-1:0] eline,
                                 logic [UNCLOSED_W-1:0] cnt);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            $display("%0t ns: unexpected verdict, expected none, got status %0d line %0d count %0d",
                     $time, st, eline, cnt);
            mismatches++;
            return;
         end
         want = pending_verdicts.pop_front();
         verdicts_checked++;
         status_tally[want.status]++;
         compare_field("status", 32'(want.status), 32'(st));
         compare_field("error_line", 32'(want.error_line), 32'(eline));
         compare_field("unclosed_count", 32'(want.unclosed), 32'(cnt));
      endfunction
   endclass

   // Every input has a known value from time zero on, and reset is held at the start.
   logic                    clock;
   logic                    reset              = 1'b1;
   logic                    req_valid          = 1'b0;
   logic                    req_ready;
   logic                    req_type           = REQ_TEXT;
   logic [7:0]              req_text_byte      = 8'h00;
   logic                    rsp_valid;
   logic                    rsp_ready          = 1'b0;
   logic [3:0]              rsp_status;
   logic [ERROR_LINE_W-1:0] rsp_error_line;
   logic [UNCLOSED_W-1:0]   rsp_unclosed_count;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int cycle_count   = 0;

   bracket_scoreboard ledger = new();

   c_source_bracket_balance_checker_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_text_byte      (req_text_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_error_line     (rsp_error_line),
      .rsp_unclosed_count (rsp_unclosed_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The watchdog ends a hung run with the failure message.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d verdicts outstanding.",
                  cycle_count, ledger.pending_verdicts.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side. Handshake signals are sampled right at the edge, so the values seen here
   // are the ones the block saw. The ready for the next cycle is then drawn against the stall
   // percentage of the current phase.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_result(rsp_status, rsp_error_line, rsp_unclosed_count);
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Offers one word and returns at the edge that accepts it. The sender may first go idle
   // for a random stretch. Without a gap, valid simply stays high into the next word.
   task automatic send_word(logic kind, logic [7:0] c);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_text_byte <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.note_word(kind, c);
   endtask

   // The text byte of an end word is ignored by the block, so it carries random bits.
   task automatic send_end();
      send_word(REQ_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_word(REQ_TEXT, s[i]);
      send_end();
   endtask

   // Content byte for literals and comments. It is mostly letters, with many steering
   // characters and now and then any byte at all.
   function automatic logic [7:0] body_byte();
      case ($urandom_range(0, 9))
         0:          return 8'($urandom_range(0, 255));
         1, 2, 3, 4: return LEXICON[$urandom_range(0, 11)];
         default:    return 8'($urandom_range(97, 122));
      endcase
   endfunction

   // Builds one piece of C-like text. Most openers are closed in order, and literals and
   // comments are mostly terminated. Stray closers, unterminated pieces and random bytes
   // supply the broken cases.
   function automatic void build_text(ref logic [7:0] text[$]);
      logic [7:0] closers[$];
      int         pick;
      repeat ($urandom_range(2, 14)) begin
         case ($urandom_range(0, 11))
            0, 1: begin
               pick = $urandom_range(0, 2);
               text.push_back(LEXICON[2 * pick]);
               closers.push_back(LEXICON[2 * pick + 1]);
            end
            2: begin
               if (closers.size() != 0) text.push_back(closers.pop_back());
               else text.push_back(LEXICON[2 * $urandom_range(0, 2) + 1]);
            end
            3, 4: begin
               pick = $urandom_range(0, 1);
               text.push_back(pick ? CH_DQUOTE : CH_SQUOTE);
               repeat ($urandom_range(0, 5)) begin
                  if ($urandom_range(0, 4) == 0) text.push_back(CH_BACKSLASH);
                  text.push_back(body_byte());
               end
               if ($urandom_range(0, 9) != 0) text.push_back(pick ? CH_DQUOTE : CH_SQUOTE);
            end
            5: begin
               text.push_back(CH_SLASH);
               text.push_back(CH_SLASH);
               repeat ($urandom_range(0, 6)) text.push_back(body_byte());
               if ($urandom_range(0, 9) != 0) text.push_back(CH_NEWLINE);
            end
            6: begin
               text.push_back(CH_SLASH);
               text.push_back(CH_STAR);
               repeat ($urandom_range(0, 6))
                  text.push_back($urandom_range(0, 2) == 0 ? CH_STAR : body_byte());
               if ($urandom_range(0, 9) != 0) begin
                  text.push_back(CH_STAR);
                  text.push_back(CH_SLASH);
               end
            end
            7: text.push_back(CH_NEWLINE);
            8: text.push_back(8'($urandom_range(0, 255)));
            9: begin
               text.push_back(CH_SLASH);
               text.push_back(8'($urandom_range(97, 122)));
            end
            default: repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(97, 122)));
         endcase
      end
      if ($urandom_range(0, 9) < 7)
         while (closers.size() != 0) text.push_back(closers.pop_back());
   endfunction

   initial begin
      logic [7:0] text[$];
      int         phase_words;
      int         phase_texts;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed texts, with no idling on either side.
      // An escaped newline inside a string still counts a line, so the stray ')' is on line 2.
      send_text("\"\\\n\")");
      // After a stray '}', everything else is ignored, newlines included.
      send_text("\n}\n)(");
      // A double star before the slash still closes the comment. A trailing '/' does nothing.
      send_text("/*a**/(/");
      // A line comment ends at the newline. Then comes a char literal that is never closed,
      // filled with the extreme byte values. That case is not flagged.
      send_word(REQ_TEXT, CH_SLASH);
      send_word(REQ_TEXT, CH_SLASH);
      send_word(REQ_TEXT, CH_RBRACKET);
      send_word(REQ_TEXT, CH_NEWLINE);
      send_word(REQ_TEXT, CH_SQUOTE);
      send_word(REQ_TEXT, 8'h00);
      send_word(REQ_TEXT, 8'hFF);
      send_word(REQ_TEXT, 8'h01);
      send_end();
      send_text("\"ab");        // string left open
      send_text("/**");         // block comment left open
      send_text("{[a/b");       // braces take priority over brackets
      send_text("[x/");         // only a bracket left open
      send_text("'\\'']");      // escaped quote inside a char literal, then a stray ']'

      // Random texts, phase by phase, until each phase has both enough words and enough
      // verdicts.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct <= SEND_IDLE[phase];
         stall_pct     <= RSP_STALL[phase];
         phase_words = 0;
         phase_texts = 0;
         while (phase_words < 160 || phase_texts < 6) begin
            text.delete();
            build_text(text);
            foreach (text[i]) send_word(REQ_TEXT, text[i]);
            send_end();
            phase_words += text.size() + 1;
            phase_texts++;
         end
      end
      req_valid <= 1'b0;

      // Let the last verdicts drain, then keep watching for anything extra.
      while (ledger.pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Scanned %0d words and checked %0d verdicts: %0d clean, %0d stray closers,",
               ledger.words_seen, ledger.verdicts_checked, ledger.status_tally[ST_OK],
               ledger.status_tally[ST_STRAY_PAREN] + ledger.status_tally[ST_STRAY_BRACE]
               + ledger.status_tally[ST_STRAY_BRACKET]);
      $display("%0d open literals or comments, %0d unclosed openers; %0d mismatches.",
               ledger.status_tally[ST_OPEN_STRING] + ledger.status_tally[ST_OPEN_COMMENT],
               ledger.status_tally[ST_OPEN_BRACES] + ledger.status_tally[ST_OPEN_PARENS]
               + ledger.status_tally[ST_OPEN_BRACKETS], ledger.mismatches);
      if (ledger.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
